@@ sv/hps_pkg.sv @@
`default_nettype none

package hps_pkg;

  localparam int NUM_COEFS = 20;
  localparam int CIDX_W    = (NUM_COEFS > 1) ? $clog2(NUM_COEFS) : 1;
  localparam int K_W       = $clog2(NUM_COEFS + 1);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [31:0] QNAN    = 32'h7FC0_0000;
  localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
  localparam logic [31:0] FP_INF  = 32'h7F80_0000;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  localparam int WIN_W  = 103;
  localparam int C_TOP  = 78;
  localparam int P_BASE = 28;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_DATA = 1'b1
  } func_e;

  typedef struct packed {
    logic        func;
    logic [4:0]  coef_index;
    logic [31:0] coef_value;
    logic [31:0] sample;
    logic        last;
  } hps_in_t;

  typedef struct packed {
    logic [31:0] sum_bits;
    logic [31:0] sample_count;
  } hps_out_t;

  typedef struct packed {
    logic              is_data;
    logic [CIDX_W-1:0] idx;
    logic [31:0]       data;
    logic              last;
  } hps_entry_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } fma_req_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] result;
  } fma_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HORNER_ISSUE,
    ST_HORNER_WAIT,
    ST_SUM_ISSUE,
    ST_SUM_WAIT,
    ST_EMIT
  } back_state_e;

endpackage

`default_nettype wire

@@ sv/hps_front.sv @@
`default_nettype none

module hps_front import hps_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire hps_in_t    item_i,
  output logic            full_o,
  output logic            q_push_o,
  output hps_entry_t      q_entry_o,
  input  wire logic       q_full_i
);

  logic accept;
  logic is_data;
  logic idx_ok;
  logic seen_q;

  assign accept  = push_i && !full_o;
  assign is_data = (item_i.func == FUNC_DATA);
  assign idx_ok  = ({27'd0, item_i.coef_index} < 32'(NUM_COEFS));

  // Loads to slots past the table are dropped here and never reach the queue.
  assign q_push_o          = accept && (is_data || idx_ok);
  assign q_entry_o.is_data = is_data;
  assign q_entry_o.idx     = CIDX_W'(item_i.coef_index);
  assign q_entry_o.data    = is_data ? item_i.sample : item_i.coef_value;
  assign q_entry_o.last    = is_data && item_i.last;
  assign full_o            = q_full_i || !seen_q;

  // The front stays closed after reset until the first clock edge sets seen_q.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else begin
      seen_q <= 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ sv/hps_queue.sv @@
`default_nettype none

module hps_queue import hps_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire hps_entry_t entry_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output hps_entry_t      entry_o,
  output logic            empty_o
);

  hps_entry_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d;
  logic [QPTR_W-1:0]   rd_q, rd_d;
  logic [QPTR_W:0]     cnt_q, cnt_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (cnt_q == (QPTR_W + 1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/hps_fma.sv @@
`default_nettype none

module hps_fma import hps_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire fma_req_t req_i,
  output fma_rsp_t      rsp_o
);

  // Stage 1: unpack, special operands, significand product.
  logic [7:0]        ea, eb, ec;
  logic [23:0]       sa, sb, sc;
  logic [8:0]        ea_e, eb_e, ec_e;
  logic              a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero;
  logic              ps1, cs1;
  logic              spec1;
  logic [31:0]       spec_val1;

  logic              v1_q;
  logic [47:0]       prod_q;
  logic              ps1_q, cs1_q;
  logic [23:0]       sc_q;
  logic signed [11:0] lp_q, lc_q;
  logic              spec1_q;
  logic [31:0]       spec_val1_q;

  assign ea = req_i.a[30:23];
  assign eb = req_i.b[30:23];
  assign ec = req_i.c[30:23];
  assign sa = {(ea != 8'd0), req_i.a[22:0]};
  assign sb = {(eb != 8'd0), req_i.b[22:0]};
  assign sc = {(ec != 8'd0), req_i.c[22:0]};
  assign ea_e = (ea == 8'd0) ? 9'd1 : {1'b0, ea};
  assign eb_e = (eb == 8'd0) ? 9'd1 : {1'b0, eb};
  assign ec_e = (ec == 8'd0) ? 9'd1 : {1'b0, ec};

  assign a_nan  = (ea == 8'hFF) && (req_i.a[22:0] != '0);
  assign b_nan  = (eb == 8'hFF) && (req_i.b[22:0] != '0);
  assign c_nan  = (ec == 8'hFF) && (req_i.c[22:0] != '0);
  assign a_inf  = (ea == 8'hFF) && (req_i.a[22:0] == '0);
  assign b_inf  = (eb == 8'hFF) && (req_i.b[22:0] == '0);
  assign c_inf  = (ec == 8'hFF) && (req_i.c[22:0] == '0);
  assign a_zero = (req_i.a[30:0] == '0);
  assign b_zero = (req_i.b[30:0] == '0);
  assign ps1    = req_i.a[31] ^ req_i.b[31];
  assign cs1    = req_i.c[31];

  always_comb begin
    spec1     = 1'b1;
    spec_val1 = QNAN;
    if (a_nan || b_nan || c_nan || (a_inf && b_zero) || (b_inf && a_zero) ||
        ((a_inf || b_inf) && c_inf && (ps1 != cs1))) begin
      spec_val1 = QNAN;
    end else if (a_inf || b_inf) begin
      spec_val1 = {ps1, FP_INF[30:0]};
    end else if (c_inf) begin
      spec_val1 = {cs1, FP_INF[30:0]};
    end else begin
      spec1 = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q      <= 48'(sa) * 48'(sb);
    ps1_q       <= ps1;
    cs1_q       <= cs1;
    sc_q        <= sc;
    lp_q        <= $signed(12'(ea_e) + 12'(eb_e)) - 12'sd300;
    lc_q        <= $signed(12'(ec_e)) - 12'sd150;
    spec1_q     <= spec1;
    spec_val1_q <= spec_val1;
  end

  // Stage 2: align the addend against the product and add.
  logic signed [11:0] cpos;
  logic signed [11:0] nsh;
  logic               c_dom;
  logic [WIN_W-1:0]   pw, cw;
  logic signed [11:0] e0;
  logic               eff_sub;

  logic               v2_q;
  logic [WIN_W:0]     sum_q;
  logic               ps2_q, cs2_q, sub2_q;
  logic signed [11:0] e0_2_q;
  logic               spec2_q;
  logic [31:0]        spec_val2_q;

  assign cpos    = lc_q - lp_q + 12'sd28;
  assign nsh     = -cpos;
  assign c_dom   = (prod_q == '0) || (cpos > 12'(C_TOP));
  assign eff_sub = ps1_q != cs1_q;

  always_comb begin
    if (c_dom) begin
      pw = WIN_W'(prod_q != '0);
      cw = WIN_W'(sc_q) << C_TOP;
      e0 = lc_q - 12'(C_TOP);
    end else begin
      pw = WIN_W'(prod_q) << P_BASE;
      e0 = lp_q - 12'(P_BASE);
      if (cpos >= 12'sd0) begin
        cw = WIN_W'(sc_q) << cpos[6:0];
      end else if (nsh >= 12'sd24) begin
        cw = WIN_W'(sc_q != '0);
      end else begin
        cw = WIN_W'(sc_q >> nsh[4:0]) |
             WIN_W'((sc_q & ~(24'hFF_FFFF << nsh[4:0])) != '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q       <= eff_sub ? ({1'b0, pw} - {1'b0, cw}) : ({1'b0, pw} + {1'b0, cw});
    ps2_q       <= ps1_q;
    cs2_q       <= cs1_q;
    sub2_q      <= eff_sub;
    e0_2_q      <= e0;
    spec2_q     <= spec1_q;
    spec_val2_q <= spec_val1_q;
  end

  // Stage 3: magnitude and sign.
  logic               v3_q;
  logic [WIN_W-1:0]   mag3_q;
  logic               sign3_q, zsign3_q;
  logic signed [11:0] e0_3_q;
  logic               spec3_q;
  logic [31:0]        spec_val3_q;
  logic [WIN_W:0]     neg_sum;

  assign neg_sum = -sum_q;

  always_ff @(posedge clk_i) begin
    mag3_q      <= sum_q[WIN_W] ? neg_sum[WIN_W-1:0] : sum_q[WIN_W-1:0];
    sign3_q     <= (sub2_q && sum_q[WIN_W]) ? cs2_q : ps2_q;
    zsign3_q    <= ps2_q && cs2_q;
    e0_3_q      <= e0_2_q;
    spec3_q     <= spec2_q;
    spec_val3_q <= spec_val2_q;
  end

  // Stage 4: leading one, result exponent and rounding position.
  logic [6:0]         msb;
  logic signed [11:0] e_msb;
  logic signed [11:0] lsb_pos;
  logic signed [11:0] shv;
  logic               normal;

  logic               v4_q;
  logic [WIN_W-1:0]   mag4_q;
  logic               sign4_q, zsign4_q, zero4_q;
  logic [6:0]         sh4_q;
  logic [9:0]         base4_q;
  logic               spec4_q;
  logic [31:0]        spec_val4_q;

  always_comb begin
    msb = '0;
    for (int i = 0; i < WIN_W; i++) begin
      if (mag3_q[i]) begin
        msb = 7'(i);
      end
    end
  end

  assign e_msb   = e0_3_q + $signed({5'd0, msb});
  assign normal  = e_msb >= -12'sd126;
  assign lsb_pos = normal ? ($signed({5'd0, msb}) - 12'sd23) : (-12'sd149 - e0_3_q);
  assign shv     = lsb_pos + 12'sd23;

  always_ff @(posedge clk_i) begin
    mag4_q      <= mag3_q;
    sign4_q     <= sign3_q;
    zsign4_q    <= zsign3_q;
    zero4_q     <= (mag3_q == '0);
    sh4_q       <= (shv > 12'sd127) ? 7'd127 : shv[6:0];
    base4_q     <= normal ? 10'(e_msb + 12'sd126) : 10'd0;
    spec4_q     <= spec3_q;
    spec_val4_q <= spec_val3_q;
  end

  // Stage 5: shift to the rounding position, round to nearest even, pack.
  logic [127:0] zw;
  logic [127:0] shifted;
  logic         sticky;
  logic         up;
  logic [24:0]  sig_r;
  logic [33:0]  mag34;
  logic [31:0]  res;
  logic [31:0]  res_q;
  logic         rsp_valid_q;

  assign zw      = {1'b0, mag4_q, 24'd0};
  assign shifted = zw >> sh4_q;
  assign sticky  = (zw & ~({128{1'b1}} << sh4_q)) != '0;
  assign up      = shifted[0] && (sticky || shifted[1]);
  assign sig_r   = {1'b0, shifted[24:1]} + 25'(up);
  assign mag34   = {1'b0, base4_q, 23'd0} + 34'(sig_r);

  always_comb begin
    if (spec4_q) begin
      res = spec_val4_q;
    end else if (zero4_q) begin
      res = {zsign4_q, 31'd0};
    end else if (mag34 >= 34'(FP_INF)) begin
      res = {sign4_q, FP_INF[30:0]};
    end else begin
      res = {sign4_q, mag34[30:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      v1_q        <= req_i.valid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      rsp_valid_q <= v4_q;
    end
  end

  assign rsp_o = '{valid: rsp_valid_q, result: res_q};

endmodule

`default_nettype wire

@@ sv/hps_back.sv @@
`default_nettype none

module hps_back import hps_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire hps_entry_t q_entry_i,
  input  wire logic       q_empty_i,
  output logic            q_pop_o,
  output fma_req_t        fma_req_o,
  input  wire fma_rsp_t   fma_rsp_i,
  output hps_out_t        res_o,
  output logic            empty_o,
  input  wire logic       pop_i
);

  back_state_e      state_q, state_d;
  logic [K_W-1:0]   k_q;
  logic [31:0]      p_q, v_q;
  logic             last_q;
  logic [31:0]      sum_q, cnt_q;
  logic [31:0]      coef_q [NUM_COEFS];
  hps_out_t         out_q;
  logic             out_valid_q, out_valid_d;
  logic             take;
  logic             emit_fire;
  logic             k_end;

  assign take      = (state_q == ST_IDLE) && !q_empty_i;
  assign k_end     = (k_q == K_W'(NUM_COEFS - 1));
  assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || pop_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take && q_entry_i.is_data) begin
          state_d = (NUM_COEFS > 1) ? ST_HORNER_ISSUE : ST_SUM_ISSUE;
        end
      end
      ST_HORNER_ISSUE: state_d = ST_HORNER_WAIT;
      ST_HORNER_WAIT: begin
        if (fma_rsp_i.valid) begin
          state_d = k_end ? ST_SUM_ISSUE : ST_HORNER_ISSUE;
        end
      end
      ST_SUM_ISSUE: state_d = ST_SUM_WAIT;
      ST_SUM_WAIT: begin
        if (fma_rsp_i.valid) begin
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o         = take;
    fma_req_o.valid = (state_q == ST_HORNER_ISSUE) || (state_q == ST_SUM_ISSUE);
    fma_req_o.a     = p_q;
    if (state_q == ST_SUM_ISSUE) begin
      fma_req_o.b = FP_ONE;
      fma_req_o.c = sum_q;
    end else begin
      fma_req_o.b = v_q;
      fma_req_o.c = coef_q[k_q[CIDX_W-1:0]];
    end
  end

  assign out_valid_d = emit_fire ? 1'b1 : (pop_i ? 1'b0 : out_valid_q);
  assign res_o       = out_q;
  assign empty_o     = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (take && q_entry_i.is_data) begin
        k_q <= K_W'(1);
      end else if ((state_q == ST_HORNER_WAIT) && fma_rsp_i.valid) begin
        k_q <= k_q + 1'b1;
      end
      if ((state_q == ST_SUM_WAIT) && fma_rsp_i.valid) begin
        sum_q <= fma_rsp_i.result;
        if (cnt_q != CNT_MAX) begin
          cnt_q <= cnt_q + 32'd1;
        end
      end else if (emit_fire) begin
        sum_q <= '0;
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !q_entry_i.is_data) begin
      coef_q[q_entry_i.idx] <= q_entry_i.data;
    end
    if (take && q_entry_i.is_data) begin
      v_q    <= q_entry_i.data;
      last_q <= q_entry_i.last;
      p_q    <= coef_q[0];
    end else if ((state_q == ST_HORNER_WAIT) && fma_rsp_i.valid) begin
      p_q <= fma_rsp_i.result;
    end
    if (emit_fire) begin
      out_q.sum_bits     <= sum_q;
      out_q.sample_count <= cnt_q;
    end
  end

endmodule

`default_nettype wire

@@ sv/horner_poly_sum.sv @@
`default_nettype none

// Channel   Direction  Handshake             Payload
// input     in         push / full           item_i   (hps_in_t)
// result    out        empty / pop           result_o (hps_out_t)
//
// A load item passes through the queue and reaches the table when the back end takes it.
// A data item holds the back end while the five-stage fused multiply-add unit serves
// each Horner step and then the final sum in turn, and a data item that carries last
// also passes through the emit state before the back end takes the next item.
// Reset clears the queue, the run sum, the count and the result valid flag.
// A four-entry queue lets the input side keep accepting while the back end
// works or waits for a result to be popped.
module horner_poly_sum import hps_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push,
  input  wire hps_in_t item_i,
  output logic         full,
  output logic         empty,
  input  wire logic    pop,
  output hps_out_t     result_o
);

  logic       q_push;
  hps_entry_t q_in;
  logic       q_full;
  logic       q_pop;
  hps_entry_t q_out;
  logic       q_empty;
  fma_req_t   fma_req;
  fma_rsp_t   fma_rsp;

  hps_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .item_i    (item_i),
    .full_o    (full),
    .q_push_o  (q_push),
    .q_entry_o (q_in),
    .q_full_i  (q_full)
  );

  hps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (q_out),
    .empty_o (q_empty)
  );

  hps_fma u_fma (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fma_req),
    .rsp_o  (fma_rsp)
  );

  hps_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_entry_i (q_out),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .fma_req_o (fma_req),
    .fma_rsp_i (fma_rsp),
    .res_o     (result_o),
    .empty_o   (empty),
    .pop_i     (pop)
  );

endmodule

`default_nettype wire
